// ===== hw/rtl/tnbm_pkg.sv =====
// shared types, codes and tanh table for the tanh neuron
package tnbm_pkg;
	localparam logic [2:0] ACT_LOAD_W  = 3'd0;
	localparam logic [2:0] ACT_LOAD_D  = 3'd1;
	localparam logic [2:0] ACT_FWD     = 3'd2;
	localparam logic [2:0] ACT_TARGET  = 3'd3;
	localparam logic [2:0] ACT_HIDDEN  = 3'd4;
	localparam logic [2:0] ACT_UPDATE  = 3'd5;

	localparam logic [1:0] KIND_ACT  = 2'd0;
	localparam logic [1:0] KIND_GRAD = 2'd1;
	localparam logic [1:0] KIND_WGT  = 2'd2;

	localparam logic REG_ETA   = 1'b0;
	localparam logic REG_ALPHA = 1'b1;

	typedef struct packed {
		logic [2:0]         action;
		logic               ok;
		logic               last;
		logic signed [15:0] value;
		logic signed [15:0] weight_in;
	} cmd_t;

	function automatic logic [11:0] tanh_tab(input logic [4:0] i);
		logic [11:0] r;
		case (i)
			5'd0: r = 12'd0;
			5'd1: r = 12'd1003;
			5'd2: r = 12'd1893;
			5'd3: r = 12'd2602;
			5'd4: r = 12'd3119;
			5'd5: r = 12'd3475;
			5'd6: r = 12'd3707;
			5'd7: r = 12'd3856;
			5'd8: r = 12'd3949;
			5'd9: r = 12'd4006;
			5'd10: r = 12'd4041;
			5'd11: r = 12'd4062;
			5'd12: r = 12'd4076;
			5'd13: r = 12'd4084;
			5'd14: r = 12'd4089;
			5'd15: r = 12'd4091;
			default: r = 12'd4093;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'sh7fff;
		if (v < -48'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) return 32'sh7fffffff;
		if (v < -48'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

// ===== hw/rtl/tnbm_front.sv =====
// front end: input handshake, index check and item queue
module tnbm_front import tnbm_pkg::*; #(
	parameter int MAX_INPUTS = 64,
	parameter int IW = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [5:0]         index,
	input  logic signed [15:0] value,
	input  logic signed [15:0] weight_in,
	input  logic               last,
	output logic               q_valid,
	input  logic               q_take,
	output cmd_t               q_cmd,
	output logic [IW-1:0]      q_idx
);
	cmd_t          cmd_q [2];
	logic [IW-1:0] idx_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          push;
	cmd_t          c;

	assign in_stall = cnt_q[1];
	assign push = in_valid && !in_stall;
	assign q_valid = cnt_q != 2'd0;
	assign q_cmd = cmd_q[rp_q];
	assign q_idx = idx_q[rp_q];

	always_comb begin
		c.action = action;
		c.ok = 32'(index) < MAX_INPUTS;
		c.last = last;
		c.value = value;
		c.weight_in = weight_in;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wp_q] <= c;
			idx_q[wp_q] <= IW'(index);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_take) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end
endmodule

// ===== hw/rtl/tnbm_back.sv =====
// back end: stores, shared multiplier sequencer and result register
module tnbm_back import tnbm_pkg::*; #(
	parameter int MAX_INPUTS = 64,
	parameter int IW = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               q_valid,
	output logic               q_take,
	input  cmd_t               q_cmd,
	input  logic [IW-1:0]      q_idx,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [5:0]         result_index,
	output logic signed [15:0] result_value
);
	typedef enum logic [2:0] {S_IDLE, S_READ, S_SQ, S_M1, S_M2, S_M3, S_RES, S_DONE} st_t;

	logic signed [15:0] w_mem [MAX_INPUTS];
	logic signed [15:0] d_mem [MAX_INPUTS];
	logic signed [15:0] a_mem [MAX_INPUTS];
	logic signed [15:0] w_rd_q, d_rd_q, a_rd_q;

	st_t                st_q;
	cmd_t               cmd_q;
	logic [IW-1:0]      idx_q;
	logic [15:0]        eta_q, alpha_q;
	logic signed [31:0] acc_q;
	logic signed [15:0] y_q, grad_q, deriv_q;
	logic signed [47:0] p_q;
	logic signed [31:0] m_q;
	logic [1:0]         rkind_q;
	logic [5:0]         ridx_q;
	logic signed [15:0] rval_q;
	logic               wr_w, wr_d;
	logic signed [15:0] wr_wv, wr_dv;

	logic signed [32:0] ma, mb;
	logic signed [47:0] mp;

	logic signed [31:0] sum_acc;
	logic [31:0]        mag32;
	logic [19:0]        mag;
	logic [11:0]        t0, t1, ty;
	logic signed [15:0] y_new;
	logic signed [15:0] diff, dow, nd, nw, gnew;
	logic signed [32:0] yy;

	assign mp = 48'(ma) * 48'(mb);
	assign q_take = (st_q == S_IDLE) && q_valid;

	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			S_READ: begin
				if (cmd_q.action == ACT_FWD) begin
					ma = 33'(cmd_q.value);
					mb = 33'(w_rd_q);
				end else if (cmd_q.action == ACT_HIDDEN) begin
					ma = 33'(cmd_q.value);
					mb = 33'(cmd_q.weight_in);
				end else if (cmd_q.action == ACT_UPDATE) begin
					ma = 33'(a_rd_q);
					mb = 33'(grad_q);
				end else begin
					ma = 33'(y_q);
					mb = 33'(y_q);
				end
			end
			S_SQ: begin
				ma = 33'(y_q);
				mb = 33'(y_q);
			end
			S_M1: begin
				if (cmd_q.action == ACT_UPDATE) begin
					ma = $signed({17'd0, eta_q});
					mb = 33'($signed(p_q[31:0]));
				end
			end
			S_M2: begin
				if (cmd_q.action == ACT_UPDATE) begin
					ma = $signed({17'd0, alpha_q});
					mb = 33'(d_rd_q);
				end else begin
					ma = 33'(cmd_q.action == ACT_TARGET ? diff : dow);
					mb = 33'(deriv_q);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		sum_acc = sat32(48'(acc_q) + 48'(p_q));
		mag32 = acc_q[31] ? 32'(-33'(acc_q)) : 32'(acc_q);
		mag = mag32[31:12];
		t0 = tanh_tab(mag[14:10]);
		t1 = tanh_tab(5'(mag[14:10]) + 5'd1);
		ty = (mag >= 20'd16384) ? tanh_tab(5'd16)
			: t0 + 12'((23'(t1 - t0) * 23'(mag[9:0])) >> 10);
		y_new = acc_q[31] ? -$signed({4'd0, ty}) : $signed({4'd0, ty});
		diff = sat16(48'(cmd_q.value) - 48'(y_q));
		dow = sat16(48'(acc_q >>> 12));
		yy = 33'(p_q >>> 12);
		nd = sat16(48'(p_q >>> 28) + 48'(m_q >>> 16));
		nw = sat16(48'(w_rd_q) + 48'(nd));
		gnew = sat16(48'(p_q >>> 12));
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			w_rd_q <= w_mem[q_idx];
			d_rd_q <= d_mem[q_idx];
			a_rd_q <= a_mem[q_idx];
		end
		if (wr_w) w_mem[idx_q] <= wr_wv;
		if (wr_d) d_mem[idx_q] <= wr_dv;
		if (st_q == S_READ && cmd_q.action == ACT_FWD && cmd_q.ok)
			a_mem[idx_q] <= cmd_q.value;
	end

	always_comb begin
		wr_w = 1'b0;
		wr_d = 1'b0;
		wr_wv = cmd_q.value;
		wr_dv = cmd_q.value;
		if (st_q == S_READ && cmd_q.ok) begin
			wr_w = cmd_q.action == ACT_LOAD_W;
			wr_d = cmd_q.action == ACT_LOAD_D;
		end
		if (st_q == S_M3 && cmd_q.action == ACT_UPDATE) begin
			wr_w = 1'b1;
			wr_d = 1'b1;
			wr_wv = nw;
			wr_dv = nd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			eta_q <= 16'd9830;
			alpha_q <= 16'd32768;
			acc_q <= '0;
			y_q <= '0;
			grad_q <= '0;
			deriv_q <= '0;
			out_valid <= 1'b0;
			kind <= KIND_ACT;
			result_index <= '0;
			result_value <= '0;
			rkind_q <= KIND_ACT;
			ridx_q <= '0;
			rval_q <= '0;
			cmd_q <= '0;
			idx_q <= '0;
			p_q <= '0;
			m_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ETA) eta_q <= cfg_data;
				else alpha_q <= cfg_data;
			end
			if (st_q == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (q_take) begin
					cmd_q <= q_cmd;
					idx_q <= q_idx;
					st_q <= S_READ;
				end
				S_READ: begin
					p_q <= (cmd_q.action == ACT_FWD && !cmd_q.ok) ? '0 : mp;
					case (cmd_q.action)
						ACT_FWD: st_q <= S_M3;
						ACT_HIDDEN: st_q <= S_M3;
						ACT_TARGET: st_q <= S_M1;
						ACT_UPDATE: st_q <= cmd_q.ok ? S_M1 : S_IDLE;
						default: st_q <= S_IDLE;
					endcase
				end
				S_SQ: begin
					p_q <= mp;
					st_q <= S_M1;
				end
				S_M1: begin
					if (cmd_q.action == ACT_UPDATE) p_q <= mp;
					else deriv_q <= sat16(48'sd4096 - 48'(yy));
					st_q <= S_M2;
				end
				S_M2: begin
					if (cmd_q.action == ACT_UPDATE) begin
						m_q <= mp[31:0];
						st_q <= S_M3;
					end else begin
						p_q <= mp;
						st_q <= S_RES;
					end
				end
				S_M3: begin
					if (cmd_q.action == ACT_UPDATE) begin
						rkind_q <= KIND_WGT;
						ridx_q <= 6'(idx_q);
						rval_q <= nw;
						st_q <= S_DONE;
					end else begin
						acc_q <= sum_acc;
						if (!cmd_q.last) st_q <= S_IDLE;
						else if (cmd_q.action == ACT_FWD) st_q <= S_RES;
						else st_q <= S_SQ;
					end
				end
				S_RES: begin
					ridx_q <= '0;
					st_q <= S_DONE;
					if (cmd_q.action == ACT_FWD) begin
						y_q <= y_new;
						acc_q <= '0;
						rkind_q <= KIND_ACT;
						rval_q <= y_new;
					end else begin
						grad_q <= gnew;
						rkind_q <= KIND_GRAD;
						rval_q <= gnew;
						if (cmd_q.action == ACT_HIDDEN) acc_q <= '0;
					end
				end
				S_DONE: if (!out_valid || !out_stall) begin
					kind <= rkind_q;
					result_index <= ridx_q;
					result_value <= rval_q;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/tanh_neuron_backprop_momentum.sv =====
// top level of the tanh neuron with backpropagation and momentum
// Each item passes a two-entry queue into a sequencer that owns one shared
// multiplier and takes one item at a time: loads, unused actions and
// out-of-range updates return to idle, forward or hidden elements without
// last accumulate and go back to idle, and a forward element with last, a
// target item, an update (three multiplies) or the last hidden element ends
// by moving its result into the output register, where it waits until
// accepted; while it waits the sequencer holds the next result back.
// Weights, deltas and activations sit in three memories of MAX_INPUTS words.
module tanh_neuron_backprop_momentum import tnbm_pkg::*; #(
	parameter int MAX_INPUTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [5:0]         index,
	input  logic signed [15:0] value,
	input  logic signed [15:0] weight_in,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [5:0]         result_index,
	output logic signed [15:0] result_value
);
	localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

	logic          q_valid, q_take;
	cmd_t          q_cmd;
	logic [IW-1:0] q_idx;

	tnbm_front #(.MAX_INPUTS(MAX_INPUTS), .IW(IW)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .action, .index, .value,
		.weight_in, .last, .q_valid, .q_take, .q_cmd, .q_idx
	);

	tnbm_back #(.MAX_INPUTS(MAX_INPUTS), .IW(IW)) u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_take,
		.q_cmd, .q_idx, .out_valid, .out_stall, .kind, .result_index,
		.result_value
	);
endmodule
